// ===== sv/ans_enc_pkg.sv =====
// ----------------------------------------------------------------------------
// ans_enc_pkg
// Types, codes and helpers shared by the bitwise ANS encoder core.
// ----------------------------------------------------------------------------
package ans_enc_pkg;

    // Field widths
    localparam int C_STATE_W  = 17;
    localparam int C_COUNT_W  = 17;
    localparam int C_START_W  = 16;
    localparam int C_SYM_W    = 8;
    localparam int C_LTS_W    = 5;
    localparam int C_NB_W     = 5;

    // Largest supported log2 of the table size
    localparam logic [C_LTS_W-1:0] C_MAX_LOG_L = 5'd16;
    // Reset value of the table size register
    localparam logic [C_LTS_W-1:0] C_LTS_RESET = 5'd12;
    // Most bits that one encode may emit
    localparam logic [C_NB_W-1:0]  C_MAX_BITS  = 5'd16;

    // Request codes
    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_APPEND  = 2'd1;
    localparam logic [1:0] REQ_ENCODE  = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SYM   = 3'd1;
    localparam logic [2:0] ST_SUM_NOT_L = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_STATE = 3'd4;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [C_SYM_W-1:0]   symbol;
        logic [C_COUNT_W-1:0] count;
    } t_req;

    typedef struct packed {
        logic                 bit_res;
        logic                 bit_valid;
        logic                 last;
        logic [C_STATE_W-1:0] coder_state;
        logic [2:0]           status;
    } t_res;

    // One symbol table entry
    typedef struct packed {
        logic [C_START_W-1:0] start;
        logic [C_COUNT_W-1:0] count;
    } t_entry;

    // L = 2^lts, with lts clamped to 1..C_MAX_LOG_L
    function automatic logic [C_STATE_W-1:0] f_table_size(input logic [C_LTS_W-1:0] lts);
        logic [C_LTS_W-1:0] lg;
        lg = lts;
        if (lg < 5'd1) lg = 5'd1;
        if (lg > C_MAX_LOG_L) lg = C_MAX_LOG_L;
        f_table_size = C_STATE_W'(1) << lg;
    endfunction

endpackage

// ===== sv/ans_bitwise_encoder_core.sv =====
// ----------------------------------------------------------------------------
// ans_bitwise_encoder_core
// Streaming ANS encoder with bitwise renormalization and a loadable table.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_req when i_start is high and o_busy is low. Clear,
//   append and restart requests, and encodes rejected by the state or table
//   sum check, put their one result on o_res in the cycle after the accept
//   (taken at the next edge) and never raise o_busy. An encode with a bad
//   symbol raises o_busy while it reads the symbol table; its result
//   appears as the block returns to idle. An encode reads the symbol
//   table, then walks the state right one bit per cycle, counting nb
//   emitted bits, until it falls below twice the count or nb reaches 16,
//   forms the new state (the only result if nb is 0) and then shifts the
//   emitted bits out one per cycle. o_busy stays high through these steps,
//   and the next request may enter at the edge at which the last result
//   is taken; the bit serial shift and emit loops set how long this takes.
//   Each result sits on o_res for one cycle, flagged by o_res_valid; the
//   receiver cannot stall. Every result of an encode carries the final state.
//   i_cfg_we/i_cfg_data write log2 of the table size; writing only while idle is left to the user.
//   Reset (synchronous, i_rst_n low) empties the table and sets the state
//   to 4096; table contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module ans_bitwise_encoder_core #(
    parameter int MAX_SYMBOLS = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  ans_enc_pkg::t_req       i_req,
    input  logic                    i_cfg_we,
    input  logic [4:0]              i_cfg_data,
    output logic                    o_res_valid,
    output ans_enc_pkg::t_res       o_res
);
    import ans_enc_pkg::*;

    localparam int IDX_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int LOAD_W = $clog2(MAX_SYMBOLS + 1);

    // FSM codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    // Symbol table memory
    t_entry r_mem [MAX_SYMBOLS];
    t_entry r_rd;

    logic [2:0]           r_fsm;
    logic [C_LTS_W-1:0]   r_lts;
    logic [LOAD_W-1:0]    r_loaded;
    logic [C_COUNT_W-1:0] r_total;
    logic [C_STATE_W-1:0] r_ans;
    logic [C_SYM_W-1:0]   r_sym;
    logic [C_STATE_W-1:0] r_work;
    logic [C_STATE_W-1:0] r_orig;
    logic [C_COUNT_W-1:0] r_cnt;
    logic [C_START_W-1:0] r_start;
    logic [C_NB_W-1:0]    r_nb;

    logic [C_STATE_W-1:0] w_l;
    logic                 w_accept;
    logic                 w_state_ok;
    logic                 w_full;
    logic                 w_mem_we;
    logic [C_COUNT_W:0]   w_sum;
    logic [C_START_W-1:0] w_start_sat;
    logic                 w_bad_sym;
    logic                 w_shift;
    logic [C_STATE_W+1:0] w_new_state;

    // Combinational helpers
    assign w_l        = f_table_size(r_lts);
    assign w_accept   = i_start && !o_busy;
    assign o_busy     = (r_fsm != S_IDLE);
    assign w_state_ok = ({1'b0, r_ans} >= {1'b0, w_l}) &&
                        ({1'b0, r_ans} <  {w_l, 1'b0});
    assign w_full     = (r_loaded >= LOAD_W'(MAX_SYMBOLS));
    assign w_mem_we   = w_accept && (i_req.req_type == REQ_APPEND) && !w_full;
    assign w_sum      = {1'b0, r_total} + {1'b0, i_req.count};
    assign w_start_sat = (r_total > C_COUNT_W'(17'h0FFFF)) ? 16'hFFFF
                                                          : r_total[C_START_W-1:0];
    assign w_bad_sym  = ({1'b0, r_sym} >= 9'(r_loaded)) || (r_rd.count == '0);
    assign w_shift    = ({1'b0, r_work} >= {r_cnt, 1'b0}) && (r_nb < C_MAX_BITS);
    assign w_new_state = {2'b00, w_l} + {3'b000, r_start} + {2'b00, r_work}
                       - {2'b00, r_cnt};

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_loaded[IDX_W-1:0]] <= '{start: w_start_sat, count: i_req.count};
        end
        r_rd <= r_mem[i_req.symbol[IDX_W-1:0]];
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lts <= C_LTS_RESET;
        end else if (i_cfg_we) begin
            r_lts <= i_cfg_data;
        end
    end

    // Control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_loaded    <= '0;
            r_total     <= '0;
            r_ans       <= f_table_size(C_LTS_RESET);
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= 1'b0;
            case (r_fsm)
                S_IDLE: begin
                    if (w_accept) begin
                        o_res.bit_res     <= 1'b0;
                        o_res.bit_valid   <= 1'b0;
                        o_res.last        <= 1'b1;
                        o_res.coder_state <= r_ans;
                        o_res.status      <= ST_OK;
                        r_sym             <= i_req.symbol;
                        case (i_req.req_type)
                            REQ_CLEAR: begin
                                r_loaded          <= '0;
                                r_total           <= '0;
                                r_ans             <= w_l;
                                o_res.coder_state <= w_l;
                                o_res_valid       <= 1'b1;
                            end
                            REQ_RESTART: begin
                                r_ans             <= w_l;
                                o_res.coder_state <= w_l;
                                o_res_valid       <= 1'b1;
                            end
                            REQ_APPEND: begin
                                if (w_full) begin
                                    o_res.status <= ST_FULL;
                                end else begin
                                    r_loaded <= r_loaded + LOAD_W'(1);
                                    r_total  <= w_sum[C_COUNT_W] ? '1
                                                                 : w_sum[C_COUNT_W-1:0];
                                end
                                o_res_valid <= 1'b1;
                            end
                            default: begin
                                // encode: early checks, else wait for table read
                                if (!w_state_ok) begin
                                    o_res.status <= ST_BAD_STATE;
                                    o_res_valid  <= 1'b1;
                                end else if (r_total != w_l) begin
                                    o_res.status <= ST_SUM_NOT_L;
                                    o_res_valid  <= 1'b1;
                                end else begin
                                    r_fsm <= S_CHECK;
                                end
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    if (w_bad_sym) begin
                        o_res.status <= ST_BAD_SYM;
                        o_res_valid  <= 1'b1;
                        r_fsm        <= S_IDLE;
                    end else begin
                        r_cnt   <= r_rd.count;
                        r_start <= r_rd.start;
                        r_work  <= r_ans;
                        r_orig  <= r_ans;
                        r_nb    <= '0;
                        r_fsm   <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    // one renormalization step per cycle
                    if (w_shift) begin
                        r_work <= r_work >> 1;
                        r_nb   <= r_nb + C_NB_W'(1);
                    end else begin
                        r_fsm <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_ans             <= w_new_state[C_STATE_W-1:0];
                    o_res.coder_state <= w_new_state[C_STATE_W-1:0];
                    o_res.status      <= ST_OK;
                    o_res.bit_res     <= 1'b0;
                    o_res.bit_valid   <= 1'b0;
                    o_res.last        <= 1'b1;
                    if (r_nb == '0) begin
                        o_res_valid <= 1'b1;
                        r_fsm       <= S_IDLE;
                    end else begin
                        r_fsm <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // shift emitted bits out, low bit first
                    o_res.bit_res   <= r_orig[0];
                    o_res.bit_valid <= 1'b1;
                    o_res.last      <= (r_nb == C_NB_W'(1));
                    o_res_valid     <= 1'b1;
                    r_orig          <= r_orig >> 1;
                    r_nb            <= r_nb - C_NB_W'(1);
                    if (r_nb == C_NB_W'(1)) begin
                        r_fsm <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    // Assertions
    a_emit_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_EMIT) |-> (r_nb != '0))
        else $error("emit state with no bits pending");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_SHIFT) |-> (r_nb <= C_MAX_BITS))
        else $error("renormalization exceeded bit limit");

    a_burst_continuous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.bit_valid && !o_res.last) |=>
        (o_res_valid && o_res.bit_valid))
        else $error("bit burst interrupted");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy raised without a request");

endmodule
